[rtl/fsn_pkg.sv]
// Types and character constants shared by the source normaliser modules.
`default_nettype none

package fsn_pkg;

  // Characters that the lexer recognises.
  localparam logic [7:0] ChLowerA    = 8'h61;
  localparam logic [7:0] ChLowerZ    = 8'h7a;
  localparam logic [7:0] ChParenOpen = 8'h28;
  localparam logic [7:0] ChParenEnd  = 8'h29;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChDot       = 8'h2e;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChNewline   = 8'h0a;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] CaseOffset  = 8'h20;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_STRING = 2'd1,
    MODE_PAREN  = 2'd2,
    MODE_LINE   = 2'd3
  } lex_mode_e;

  typedef struct packed {
    lex_mode_e mode;
    logic      saw_dot;
    logic      error_seen;
  } lex_state_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       text_error;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/forth_source_normalizer.sv]
// Top level of the streaming source text normaliser: input register, lexer, result register.
`default_nettype none

// The normaliser takes source text one byte per item and returns exactly one
// item per byte, in order. Outside literals and comments it folds lower case
// to upper case and turns newline and tab into space; a dot followed by a
// double quote opens a string whose bytes pass raw through the closing quote;
// a parenthesis comment and a backslash comment are blanked to spaces. A
// newline inside a parenthesis comment, or a string or parenthesis comment
// still open on the byte flagged as the end of the text, raises text_error,
// which then stays set until the end of that text while later bytes pass
// unchanged. The end-of-text item returns the lexer to its reset state. The
// block sustains one item per clock cycle while the downstream side does not
// stall: an accepted item sits in the input register, and when it moves on
// the lexer step for it writes the result into the output register and
// updates the two-bit mode, the dot flag and the error flag together; the
// result then waits in the output register until the downstream side takes
// it. The lexer state, held in the mode, dot flag and error flag registers,
// is the only loop, and its update is a handful of byte compares. Both sides
// use valid and stall; in_stall_o rises only when the input register is full
// and the result register cannot drain.

module forth_source_normalizer (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  wire fsn_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output fsn_pkg::out_item_t      out_item_o
);

  logic                in_valid_q;
  logic                in_valid_d;
  fsn_pkg::in_item_t   in_item_q;
  logic                out_valid_q;
  logic                out_valid_d;
  fsn_pkg::out_item_t  out_item_q;
  fsn_pkg::lex_state_t state_q;
  fsn_pkg::lex_state_t state_d;
  fsn_pkg::out_item_t  result;
  logic                out_free;
  logic                step;
  logic                accept;

  // The result register can take a new item when it is empty or draining.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  fsn_lexer u_lexer (
    .item_i   (in_item_q),
    .state_i  (state_q),
    .result_o (result),
    .state_o  (state_d)
  );

  always_comb begin
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_comb begin
    if (step) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state: valid flags and the lexer state, which advances only when
  // an item moves from the input register into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q         <= 1'b0;
      out_valid_q        <= 1'b0;
      state_q.mode       <= fsn_pkg::MODE_NORMAL;
      state_q.saw_dot    <= 1'b0;
      state_q.error_seen <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (step) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers hold their item until it moves on.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= in_item_i;
    end
    if (step) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

[rtl/fsn_lexer.sv]
// Combinational lexer step: one byte and the current lexer state give one result and the next state.
`default_nettype none

module fsn_lexer (
  input  wire fsn_pkg::in_item_t   item_i,
  input  wire fsn_pkg::lex_state_t state_i,
  output fsn_pkg::out_item_t       result_o,
  output fsn_pkg::lex_state_t      state_o
);

  logic [7:0]         b;
  logic [7:0]         folded;
  logic [7:0]         o;
  logic               err;
  logic               dot;
  fsn_pkg::lex_mode_e mode;

  assign b = item_i.text_byte;

  always_comb begin
    if ((b >= fsn_pkg::ChLowerA) && (b <= fsn_pkg::ChLowerZ)) begin
      folded = b - fsn_pkg::CaseOffset;
    end else begin
      folded = b;
    end
  end

  always_comb begin
    err  = state_i.error_seen;
    mode = state_i.mode;
    dot  = 1'b0;
    o    = b;
    if (!state_i.error_seen) begin
      case (state_i.mode)
        fsn_pkg::MODE_NORMAL: begin
          if (state_i.saw_dot && (folded == fsn_pkg::ChQuote)) begin
            mode = fsn_pkg::MODE_STRING;
            o    = folded;
          end else if (folded == fsn_pkg::ChParenOpen) begin
            mode = fsn_pkg::MODE_PAREN;
            o    = fsn_pkg::ChSpace;
          end else if (folded == fsn_pkg::ChBackslash) begin
            mode = fsn_pkg::MODE_LINE;
            o    = fsn_pkg::ChSpace;
          end else if ((folded == fsn_pkg::ChNewline) || (folded == fsn_pkg::ChTab)) begin
            o = fsn_pkg::ChSpace;
          end else begin
            o   = folded;
            dot = (folded == fsn_pkg::ChDot);
          end
        end
        fsn_pkg::MODE_STRING: begin
          if (b == fsn_pkg::ChQuote) begin
            mode = fsn_pkg::MODE_NORMAL;
          end
        end
        fsn_pkg::MODE_PAREN: begin
          if (b == fsn_pkg::ChNewline) begin
            // A comment may not run across lines: flag it and pass the newline.
            err  = 1'b1;
            mode = fsn_pkg::MODE_NORMAL;
          end else begin
            o = fsn_pkg::ChSpace;
            if (b == fsn_pkg::ChParenEnd) begin
              mode = fsn_pkg::MODE_NORMAL;
            end
          end
        end
        default: begin
          o = fsn_pkg::ChSpace;
          if (b == fsn_pkg::ChNewline) begin
            mode = fsn_pkg::MODE_NORMAL;
          end
        end
      endcase
      if (item_i.end_of_text &&
          ((mode == fsn_pkg::MODE_STRING) || (mode == fsn_pkg::MODE_PAREN))) begin
        err = 1'b1;
      end
    end
  end

  assign result_o.out_byte   = o;
  assign result_o.out_last   = item_i.end_of_text;
  assign result_o.text_error = err;

  // The end of the text returns everything to its reset values.
  always_comb begin
    if (item_i.end_of_text) begin
      state_o.mode       = fsn_pkg::MODE_NORMAL;
      state_o.saw_dot    = 1'b0;
      state_o.error_seen = 1'b0;
    end else begin
      state_o.mode       = mode;
      state_o.saw_dot    = dot;
      state_o.error_seen = err;
    end
  end

endmodule

`default_nettype wire
